@@ rtl/sccol_pkg.sv @@
package sccol_pkg;

    // fraction bits of step_time and of the position scale
    localparam int FRAC_BITS = 16;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] STEP_RESET = 16'd1049;

    localparam int TIME_W = 17;
    localparam logic [TIME_W-1:0] TIME_ONE = 17'd65536;

    // raw-unit widths: differences, squares, dot products
    localparam int COORD_W = 32;
    localparam int RAD_IN_W = 31;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W = 2 * COORD_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int BP_W = SUM_W + 1;
    localparam int HALF_W = 32;
    localparam int BSQ_W = 2 * SUM_W;
    localparam int TT_W = 2 * CFG_W;
    localparam int TB_W = CFG_W + SUM_W;
    localparam int D_W = BSQ_W;
    localparam int Q_W = TT_W + D_W;
    localparam int M_W = TT_W + SUM_W;
    localparam int CHUNK_W = 33;

    // square root over radicand scaled by 2^(2*FRAC_BITS)
    localparam int RAD_W = Q_W + 2 * FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SQ_REM_W = ROOT_W + 2;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int N_W = TB_W + FRAC_BITS;

    // quotient needs one bit past TIME_ONE to see overflow
    localparam int QUO_W = TIME_W + 1;
    localparam int DIV_CELLS = QUO_W;
    localparam int DV_REM_W = M_W + 1;
    localparam int NPRE_W = (N_W > M_W + 2) ? N_W : M_W + 2;

    localparam int IN_TDATA_W = 320;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic decided;
        logic dec_hit;
    } verdict_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_pos_x;
        logic signed [COORD_W-1:0] a_pos_y;
        logic signed [COORD_W-1:0] b_pos_x;
        logic signed [COORD_W-1:0] b_pos_y;
        logic signed [COORD_W-1:0] a_vel_x;
        logic signed [COORD_W-1:0] a_vel_y;
        logic signed [COORD_W-1:0] b_vel_x;
        logic signed [COORD_W-1:0] b_vel_y;
        logic [RAD_IN_W-1:0]       a_radius;
        logic [RAD_IN_W-1:0]       b_radius;
    } pair_t;

    typedef struct packed {
        verdict_t              vd;
        logic [SQ_REM_W-1:0]   rem;
        logic [ROOT_W-1:0]     root;
        logic [RAD_W-1:0]      rad;
        logic [TB_W-1:0]       tb;
        logic [M_W-1:0]        m;
    } sq_item_t;

    typedef struct packed {
        verdict_t              vd;
        logic [DV_REM_W-1:0]   rem;
        logic [QUO_W-1:0]      quo;
        logic [QUO_W-1:0]      bits;
        logic [M_W-1:0]        m;
    } dv_item_t;

endpackage

@@ rtl/sccol_front.sv @@
module sccol_front
    import sccol_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  pair_t            in_item,
    input  logic [CFG_W-1:0] step_time,
    output logic             out_valid,
    output sq_item_t         out_item
);

    logic [8:0] v_reg;

    // stage 1: differences and radius sum
    logic signed [DIFF_W-1:0] ddx_reg, ddy_reg, dvx_reg, dvy_reg;
    logic [COORD_W-1:0]       rs_reg;
    // stage 2: squares and cross products
    logic [SQ_W-1:0]          pxx_reg, pyy_reg, pax_reg, pay_reg, rsq_reg;
    logic signed [SUM_W-1:0]  pbx_reg, pby_reg;
    // stage 3: sums
    logic [SUM_W-1:0]         dist_reg, am3_reg;
    logic [SQ_W-1:0]          rsq3_reg;
    logic signed [BP_W-1:0]   bp_reg;
    // stage 4: C, |b|, early verdict
    logic [SUM_W-1:0]         cp_reg, am4_reg, bm_reg;
    verdict_t                 vd4_reg;
    // stage 5: partial products
    logic [2*CHUNK_W-1:0]     bhh_reg, phh_reg;
    logic [CHUNK_W+HALF_W-1:0] bhl_reg, phl_reg, plh_reg;
    logic [2*HALF_W-1:0]      bll_reg, pll_reg;
    logic [CFG_W+CHUNK_W-1:0] tbh_reg;
    logic [CFG_W+HALF_W-1:0]  tbl_reg;
    logic [TT_W-1:0]          tt5_reg;
    logic [SUM_W-1:0]         am5_reg;
    verdict_t                 vd5_reg;
    // stage 6: b^2, A*C, T*|b|
    logic [BSQ_W-1:0]         bsq_reg, ac_reg;
    logic [TB_W-1:0]          tb6_reg;
    logic [TT_W-1:0]          tt6_reg;
    logic [SUM_W-1:0]         am6_reg;
    verdict_t                 vd6_reg;
    // stage 7: discriminant
    logic [D_W-1:0]           d_reg;
    logic [TB_W-1:0]          tb7_reg;
    logic [TT_W-1:0]          tt7_reg;
    logic [SUM_W-1:0]         am7_reg;
    verdict_t                 vd7_reg;
    // stage 8: scaling partials
    logic [TT_W+CHUNK_W-1:0]  q0_reg, q1_reg, q2_reg, m0_reg;
    logic [TT_W+D_W-3*CHUNK_W-1:0] q3_reg;
    logic [TT_W+SUM_W-CHUNK_W-1:0] m1_reg;
    logic [TB_W-1:0]          tb8_reg;
    verdict_t                 vd8_reg;
    // stage 9
    sq_item_t                 out_reg;

    logic signed [DIFF_W-1:0] ddx_next, ddy_next, dvx_next, dvy_next;
    logic [COORD_W-1:0]       rs_next;
    logic signed [2*DIFF_W-1:0] pxx_full, pyy_full, pax_full, pay_full, pbx_full, pby_full;
    logic [BP_W-1:0]          cs_next;
    logic [BP_W-1:0]          bneg_next;
    verdict_t                 vd4_next, vd7_next;
    logic [CHUNK_W-1:0]       bh, ah, ch;
    logic [HALF_W-1:0]        bl, al, cl;
    logic                     dneg;
    logic [Q_W-1:0]           q_next;
    logic [M_W-1:0]           m_next;

    always_comb
    begin
        ddx_next = {in_item.b_pos_x[COORD_W-1], in_item.b_pos_x}
                 - {in_item.a_pos_x[COORD_W-1], in_item.a_pos_x};
        ddy_next = {in_item.b_pos_y[COORD_W-1], in_item.b_pos_y}
                 - {in_item.a_pos_y[COORD_W-1], in_item.a_pos_y};
        dvx_next = {in_item.b_vel_x[COORD_W-1], in_item.b_vel_x}
                 - {in_item.a_vel_x[COORD_W-1], in_item.a_vel_x};
        dvy_next = {in_item.b_vel_y[COORD_W-1], in_item.b_vel_y}
                 - {in_item.a_vel_y[COORD_W-1], in_item.a_vel_y};
        rs_next  = {1'b0, in_item.a_radius} + {1'b0, in_item.b_radius};

        pxx_full = ddx_reg * ddx_reg;
        pyy_full = ddy_reg * ddy_reg;
        pax_full = dvx_reg * dvx_reg;
        pay_full = dvy_reg * dvy_reg;
        pbx_full = ddx_reg * dvx_reg;
        pby_full = ddy_reg * dvy_reg;

        cs_next   = {1'b0, dist_reg} - {2'b00, rsq3_reg};
        bneg_next = '0 - bp_reg;
        vd4_next.dec_hit = cs_next[BP_W-1] | (cs_next == '0);
        vd4_next.decided = vd4_next.dec_hit | (am3_reg == '0) | (step_time == '0)
                         | ~bp_reg[BP_W-1];

        bh = bm_reg[SUM_W-1:HALF_W];
        bl = bm_reg[HALF_W-1:0];
        ah = am4_reg[SUM_W-1:HALF_W];
        al = am4_reg[HALF_W-1:0];
        ch = cp_reg[SUM_W-1:HALF_W];
        cl = cp_reg[HALF_W-1:0];

        dneg = bsq_reg < ac_reg;
        vd7_next = vd6_reg;
        if (!vd6_reg.decided && dneg)
        begin
            vd7_next.decided = 1'b1;
            vd7_next.dec_hit = 1'b0;
        end

        q_next = (Q_W'(q3_reg) << (3 * CHUNK_W)) + (Q_W'(q2_reg) << (2 * CHUNK_W))
               + (Q_W'(q1_reg) << CHUNK_W) + Q_W'(q0_reg);
        m_next = (M_W'(m1_reg) << CHUNK_W) + M_W'(m0_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ddx_reg <= ddx_next;
            ddy_reg <= ddy_next;
            dvx_reg <= dvx_next;
            dvy_reg <= dvy_next;
            rs_reg  <= rs_next;

            pxx_reg <= pxx_full[SQ_W-1:0];
            pyy_reg <= pyy_full[SQ_W-1:0];
            pax_reg <= pax_full[SQ_W-1:0];
            pay_reg <= pay_full[SQ_W-1:0];
            pbx_reg <= pbx_full[SUM_W-1:0];
            pby_reg <= pby_full[SUM_W-1:0];
            rsq_reg <= rs_reg * rs_reg;

            dist_reg <= {1'b0, pxx_reg} + {1'b0, pyy_reg};
            am3_reg  <= {1'b0, pax_reg} + {1'b0, pay_reg};
            bp_reg   <= {pbx_reg[SUM_W-1], pbx_reg} + {pby_reg[SUM_W-1], pby_reg};
            rsq3_reg <= rsq_reg;

            cp_reg  <= cs_next[SUM_W-1:0];
            am4_reg <= am3_reg;
            bm_reg  <= bneg_next[SUM_W-1:0];
            vd4_reg <= vd4_next;

            bhh_reg <= bh * bh;
            bhl_reg <= bh * bl;
            bll_reg <= bl * bl;
            phh_reg <= ah * ch;
            phl_reg <= ah * cl;
            plh_reg <= al * ch;
            pll_reg <= al * cl;
            tbh_reg <= step_time * bh;
            tbl_reg <= step_time * bl;
            tt5_reg <= step_time * step_time;
            am5_reg <= am4_reg;
            vd5_reg <= vd4_reg;

            bsq_reg <= (BSQ_W'(bhh_reg) << (2 * HALF_W)) + (BSQ_W'(bhl_reg) << (HALF_W + 1))
                     + BSQ_W'(bll_reg);
            ac_reg  <= (BSQ_W'(phh_reg) << (2 * HALF_W)) + (BSQ_W'(phl_reg) << HALF_W)
                     + (BSQ_W'(plh_reg) << HALF_W) + BSQ_W'(pll_reg);
            tb6_reg <= (TB_W'(tbh_reg) << HALF_W) + TB_W'(tbl_reg);
            tt6_reg <= tt5_reg;
            am6_reg <= am5_reg;
            vd6_reg <= vd5_reg;

            d_reg   <= bsq_reg - ac_reg;
            tb7_reg <= tb6_reg;
            tt7_reg <= tt6_reg;
            am7_reg <= am6_reg;
            vd7_reg <= vd7_next;

            q0_reg  <= tt7_reg * d_reg[CHUNK_W-1:0];
            q1_reg  <= tt7_reg * d_reg[2*CHUNK_W-1:CHUNK_W];
            q2_reg  <= tt7_reg * d_reg[3*CHUNK_W-1:2*CHUNK_W];
            q3_reg  <= tt7_reg * d_reg[D_W-1:3*CHUNK_W];
            m0_reg  <= tt7_reg * am7_reg[CHUNK_W-1:0];
            m1_reg  <= tt7_reg * am7_reg[SUM_W-1:CHUNK_W];
            tb8_reg <= tb7_reg;
            vd8_reg <= vd7_reg;

            out_reg.vd   <= vd8_reg;
            out_reg.rem  <= '0;
            out_reg.root <= '0;
            out_reg.rad  <= RAD_W'(q_next) << (2 * FRAC_BITS);
            out_reg.tb   <= tb8_reg;
            out_reg.m    <= m_next;
        end
    end

    assign out_valid = v_reg[8];
    assign out_item  = out_reg;

endmodule

@@ rtl/sccol_sqrt_cell.sv @@
module sccol_sqrt_cell
    import sccol_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  sq_item_t in_item,
    output logic     out_valid,
    output sq_item_t out_item
);

    logic                  valid_reg;
    sq_item_t              item_reg;
    sq_item_t              item_next;
    logic [SQ_REM_W+1:0]   shifted;
    logic [SQ_REM_W+1:0]   trial;
    logic [SQ_REM_W+1:0]   diff;
    logic                  ge;

    // one root bit per cell: bring down two radicand bits, try root*4+1
    always_comb
    begin
        shifted = {in_item.rem, in_item.rad[RAD_W-1:RAD_W-2]};
        trial   = (SQ_REM_W+2)'({in_item.root, 2'b01});
        diff    = shifted - trial;
        ge      = shifted >= trial;
        item_next      = in_item;
        item_next.rem  = ge ? diff[SQ_REM_W-1:0] : shifted[SQ_REM_W-1:0];
        item_next.root = {in_item.root[ROOT_W-2:0], ge};
        item_next.rad  = {in_item.rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/sccol_div_cell.sv @@
module sccol_div_cell
    import sccol_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  dv_item_t in_item,
    output logic     out_valid,
    output dv_item_t out_item
);

    logic                 valid_reg;
    dv_item_t             item_reg;
    dv_item_t             item_next;
    logic [DV_REM_W:0]    shifted;
    logic [DV_REM_W:0]    dvsr;
    logic [DV_REM_W:0]    diff;
    logic                 ge;

    // restoring division, one quotient bit per cell
    always_comb
    begin
        shifted = {in_item.rem, in_item.bits[QUO_W-1]};
        dvsr    = (DV_REM_W+1)'(in_item.m);
        diff    = shifted - dvsr;
        ge      = shifted >= dvsr;
        item_next      = in_item;
        item_next.rem  = ge ? diff[DV_REM_W-1:0] : shifted[DV_REM_W-1:0];
        item_next.quo  = {in_item.quo[QUO_W-2:0], ge};
        item_next.bits = {in_item.bits[QUO_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/swept_circle_collision_time.sv @@
// order: front end, square root cells, bridge registers, divider cells, output register
// throughput: one circle pair per cycle while the cell chain is not held
// the whole chain holds only while a finished result waits on the output
// reset: rst_n is asynchronous, active low; clears all valid bits and loads step_time 1049
module swept_circle_collision_time
    import sccol_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // step_time write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,      // step_time
    // circle pair input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_vel_x, a_vel_y, b_vel_x, b_vel_y,
    // a_radius, b_radius, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // collision result output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // hit, hit_time, zero fill
);

    logic [CFG_W-1:0]  step_time_reg;
    logic              en;
    pair_t             pair;

    // front end: products and sums of the quadratic, nine stages
    logic              fr_valid;
    sq_item_t          fr_item;

    // square root chain, one root bit per cell
    logic              sq_valid [0:SQRT_CELLS];
    sq_item_t          sq_item  [0:SQRT_CELLS];

    // bridge: numerator, then overflow test and divider setup
    logic              b1_valid_reg;
    logic [N_W-1:0]    n_reg;
    logic [M_W-1:0]    b1_m_reg;
    verdict_t          b1_vd_reg;
    logic [N_W-1:0]    n_next;
    logic              ovf;

    // divider chain
    logic              dv_valid [0:DIV_CELLS];
    dv_item_t          dv_item  [0:DIV_CELLS];
    logic              b2_valid_reg;
    dv_item_t          b2_item_reg;
    dv_item_t          b2_item_next;

    // output register
    logic              out_valid_reg;
    logic              hit_reg;
    logic [TIME_W-1:0] hit_time_reg;
    logic              hit_next;
    logic [TIME_W-1:0] hit_time_next;

    // configuration is always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= STEP_RESET;
        end
        else if (cfg_valid)
        begin
            step_time_reg <= cfg_data;
        end
    end

    // the chain moves whenever the output register is free or being emptied
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign pair.a_pos_x  = s_axis_tdata[31:0];
    assign pair.a_pos_y  = s_axis_tdata[63:32];
    assign pair.b_pos_x  = s_axis_tdata[95:64];
    assign pair.b_pos_y  = s_axis_tdata[127:96];
    assign pair.a_vel_x  = s_axis_tdata[159:128];
    assign pair.a_vel_y  = s_axis_tdata[191:160];
    assign pair.b_vel_x  = s_axis_tdata[223:192];
    assign pair.b_vel_y  = s_axis_tdata[255:224];
    assign pair.a_radius = s_axis_tdata[286:256];
    assign pair.b_radius = s_axis_tdata[317:287];

    sccol_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_item   (pair),
        .step_time (step_time_reg),
        .out_valid (fr_valid),
        .out_item  (fr_item)
    );

    assign sq_valid[0] = fr_valid;
    assign sq_item[0]  = fr_item;

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        sccol_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .in_item   (sq_item[i]),
            .out_valid (sq_valid[i+1]),
            .out_item  (sq_item[i+1])
        );
    end

    // numerator: 2^FRAC_BITS * T * |b| minus the floored root
    assign n_next = (N_W'(sq_item[SQRT_CELLS].tb) << FRAC_BITS)
                  - N_W'(sq_item[SQRT_CELLS].root);

    // a quotient of 2^QUO_W or more is past the step anyway
    always_comb
    begin
        ovf = NPRE_W'(n_reg) >= (NPRE_W'(b1_m_reg) << 2);
        b2_item_next.vd   = b1_vd_reg;
        if (!b1_vd_reg.decided && ovf)
        begin
            b2_item_next.vd.decided = 1'b1;
            b2_item_next.vd.dec_hit = 1'b0;
        end
        b2_item_next.rem  = DV_REM_W'(n_reg >> 2);
        b2_item_next.quo  = '0;
        b2_item_next.bits = {n_reg[1:0], {(QUO_W-2){1'b0}}};
        b2_item_next.m    = b1_m_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= sq_valid[SQRT_CELLS];
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg       <= n_next;
            b1_m_reg    <= sq_item[SQRT_CELLS].m;
            b1_vd_reg   <= sq_item[SQRT_CELLS].vd;
            b2_item_reg <= b2_item_next;
        end
    end

    assign dv_valid[0] = b2_valid_reg;
    assign dv_item[0]  = b2_item_reg;

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        sccol_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[j]),
            .in_item   (dv_item[j]),
            .out_valid (dv_valid[j+1]),
            .out_item  (dv_item[j+1])
        );
    end

    // early verdicts win; otherwise hit when the entry time is within the step
    always_comb
    begin
        if (dv_item[DIV_CELLS].vd.decided)
        begin
            hit_next      = dv_item[DIV_CELLS].vd.dec_hit;
            hit_time_next = '0;
        end
        else if (dv_item[DIV_CELLS].quo <= QUO_W'(TIME_ONE))
        begin
            hit_next      = 1'b1;
            hit_time_next = dv_item[DIV_CELLS].quo[TIME_W-1:0];
        end
        else
        begin
            hit_next      = 1'b0;
            hit_time_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid[DIV_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg      <= hit_next;
            hit_time_reg <= hit_time_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-TIME_W-1){1'b0}}, hit_time_reg, hit_reg};

    // an empty output register never holds back the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // a miss always reports time zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> (hit_time_reg == '0))
        else $error("nonzero time on a miss");

    // entry time never exceeds one step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hit_time_reg <= TIME_ONE))
        else $error("entry time past end of step");

endmodule
